>>> rtl/core/poff_pkg.sv
package poff_pkg;

	localparam int CANVAS_WIDTH  = 1024;
	localparam int CANVAS_HEIGHT = 768;

	localparam logic [9:0] X_LIMIT = 10'(CANVAS_WIDTH - 1);
	localparam logic [9:0] Y_LIMIT = 10'(CANVAS_HEIGHT - 1);
	localparam logic [7:0] DIST_RESET = 8'd40;

	localparam int PW  = 13;
	localparam int MAW = 27;
	localparam int MBW = 19;
	localparam int MPW = MAW + MBW;

	localparam int DVD_W = 46;
	localparam int DVS_W = 27;
	localparam int RAD_W = 54;
	localparam int ROOT_W = RAD_W / 2;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [PW-1:0] trunc16(input logic [9:0] base,
			input logic signed [27:0] prod);
		logic signed [27:0] num;
		logic signed [11:0] q;
		num = $signed({2'b00, base, 16'h0000}) + prod;
		q = num[27:16];
		if (num[27] && (num[15:0] != 16'h0000))
			q = q + 12'sd1;
		return PW'(q);
	endfunction

	function automatic logic signed [PW-1:0] sat_mag(input logic [DVD_W-1:0] mag,
			input logic neg);
		logic signed [PW-1:0] r;
		if (neg) begin
			if (mag > DVD_W'(4096))
				r = 13'sh1000;
			else
				r = 13'h0000 - mag[PW-1:0];
		end else begin
			if (mag > DVD_W'(4095))
				r = 13'sh0fff;
			else
				r = mag[PW-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/poff_mul.sv
module poff_mul (
	input  logic                                clk,
	input  logic signed [poff_pkg::MAW-1:0]     a,
	input  logic signed [poff_pkg::MBW-1:0]     b,
	output logic signed [poff_pkg::MPW-1:0]     p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

>>> rtl/core/poff_sqrt.sv
module poff_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [poff_pkg::RAD_W-1:0]        rad,
	output logic [poff_pkg::ROOT_W-1:0]       root,
	output poff_pkg::unit_stat_t              stat
);

	localparam int RW = poff_pkg::ROOT_W + 3;

	logic [poff_pkg::RAD_W-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [poff_pkg::ROOT_W-1:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [RW-1:0] rem_sh, trial;

	assign rem_sh = {rem_q[RW-3:0], rad_q[poff_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(poff_pkg::ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[poff_pkg::RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[poff_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[poff_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/core/poff_div.sv
module poff_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [poff_pkg::DVD_W-1:0]        dividend,
	input  logic [poff_pkg::DVS_W-1:0]        divisor,
	output logic [poff_pkg::DVD_W-1:0]        quotient,
	output poff_pkg::unit_stat_t              stat
);

	localparam int RW = poff_pkg::DVS_W + 1;

	logic [poff_pkg::DVD_W-1:0] dvd_q;
	logic [poff_pkg::DVS_W-1:0] dvs_q;
	logic [RW-1:0] rem_q, rem_sh;
	logic [5:0] cnt_q;
	logic busy_q, done_q;

	assign rem_sh = {rem_q[RW-2:0], dvd_q[poff_pkg::DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(poff_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				dvd_q <= {dvd_q[poff_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[poff_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = dvd_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/core/polyline_offset_miter_core.sv
// polyline offset with miter join
// input channel: in_valid / in_stall carries one vertex (vertex_x, vertex_y) per item
// output channel: out_valid / out_stall carries offset points, held while stalled
// config channel: cfg_valid / cfg_ready writes offset_distance; cfg_ready is always high
// one item is worked at a time; in_stall stays high from acceptance until the last
// result of that item has been taken, and the next item can be taken in the cycle after
// first vertex: no result, back to idle
// zero-length first segment: no result, back to idle
// zero-length later segment: one result, the previous end point
// first segment: the offset start point, then the offset end point
// later segments: the miter point, or the previous end point when the lines are parallel;
// the new end follows once the miter point has been taken
// the work uses the 27-step square root and the 46-step divider, the divider used
// twice for the unit normal and twice more for the miter point
// a stalled receiver simply holds the block in its output state
// reset clears the vertex history and sets offset_distance to 40
module polyline_offset_miter_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [9:0]                vertex_x,
	input  logic [9:0]                vertex_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [12:0]        point_x,
	output logic signed [12:0]        point_y,
	output logic                      replace_last,
	output logic                      parallel_flag,
	output logic                      last_of_run,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_data
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PREP = 5'd1;
	localparam logic [4:0] S_MDX  = 5'd2;
	localparam logic [4:0] S_MDY  = 5'd3;
	localparam logic [4:0] S_LEN  = 5'd4;
	localparam logic [4:0] S_SQRT = 5'd5;
	localparam logic [4:0] S_DIVX = 5'd6;
	localparam logic [4:0] S_DIVY = 5'd7;
	localparam logic [4:0] S_MUX  = 5'd8;
	localparam logic [4:0] S_MUY  = 5'd9;
	localparam logic [4:0] S_OFSY = 5'd10;
	localparam logic [4:0] S_DET1 = 5'd11;
	localparam logic [4:0] S_DET2 = 5'd12;
	localparam logic [4:0] S_DET3 = 5'd13;
	localparam logic [4:0] S_N1A  = 5'd14;
	localparam logic [4:0] S_N1B  = 5'd15;
	localparam logic [4:0] S_N2A  = 5'd16;
	localparam logic [4:0] S_N2B  = 5'd17;
	localparam logic [4:0] S_NXA  = 5'd18;
	localparam logic [4:0] S_NXB  = 5'd19;
	localparam logic [4:0] S_NXC  = 5'd20;
	localparam logic [4:0] S_NXD  = 5'd21;
	localparam logic [4:0] S_DVX  = 5'd22;
	localparam logic [4:0] S_NYA  = 5'd23;
	localparam logic [4:0] S_NYB  = 5'd24;
	localparam logic [4:0] S_NYD  = 5'd25;
	localparam logic [4:0] S_DVY  = 5'd26;
	localparam logic [4:0] S_FIN  = 5'd27;
	localparam logic [4:0] S_OUT  = 5'd28;

	localparam int PW = poff_pkg::PW;

	logic [4:0] state_q;
	logic [7:0] dist_q;
	logic [1:0] cnt_q;
	logic [9:0] vx_q, vy_q, lx_q, ly_q;
	logic signed [10:0] dx_q, dy_q;
	logic signed [poff_pkg::MPW-1:0] acc_q;
	logic [poff_pkg::DVS_W-1:0] len_q;
	logic signed [poff_pkg::MBW-1:0] ux_q, uy_q;
	logic signed [PW-1:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [PW-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [PW-1:0] kx_q, ky_q;
	logic signed [26:0] det_q, n1_q, n2_q;
	logic neg_q, par_q;

	logic out_valid_q, rep_q, parf_q, last_q, pend_q;
	logic signed [PW-1:0] px_q, py_q, pend_x_q, pend_y_q;

	logic signed [poff_pkg::MAW-1:0] mul_a;
	logic signed [poff_pkg::MBW-1:0] mul_b;
	logic signed [poff_pkg::MPW-1:0] prod;

	logic sq_start, dv_start;
	logic [poff_pkg::RAD_W-1:0] sq_rad;
	logic [poff_pkg::ROOT_W-1:0] sq_root;
	poff_pkg::unit_stat_t sq_stat, dv_stat;
	logic [poff_pkg::DVD_W-1:0] dv_dvd, dv_q;
	logic [poff_pkg::DVS_W-1:0] dv_dvs;

	logic signed [13:0] dsx, dsy, dax, day;
	logic signed [poff_pkg::MPW-1:0] diff;
	logic [poff_pkg::DVD_W-1:0] abs_diff;
	logic [poff_pkg::DVS_W-1:0] abs_det;
	logic [10:0] abs_dx, abs_dy;
	logic [21:0] len2;
	logic [9:0] vx_in, vy_in;
	logic signed [poff_pkg::MBW-1:0] q19;

	assign dsx = 14'(sx_q) - 14'(ex_q);
	assign dsy = 14'(sy_q) - 14'(ey_q);
	assign dax = 14'(ax_q) - 14'(bx_q);
	assign day = 14'(ay_q) - 14'(by_q);
	assign diff = acc_q - prod;
	assign abs_diff = diff[poff_pkg::MPW-1] ? poff_pkg::DVD_W'(-diff) : poff_pkg::DVD_W'(diff);
	assign abs_det = det_q[26] ? 27'(-det_q) : 27'(det_q);
	assign abs_dx = dx_q[10] ? 11'(-dx_q) : 11'(dx_q);
	assign abs_dy = dy_q[10] ? 11'(-dy_q) : 11'(dy_q);
	assign len2 = acc_q[21:0] + prod[21:0];
	assign sq_rad = {len2, 32'h0};
	assign q19 = $signed(dv_q[poff_pkg::MBW-1:0]);
	assign vx_in = (vertex_x > poff_pkg::X_LIMIT) ? poff_pkg::X_LIMIT : vertex_x;
	assign vy_in = (vertex_y > poff_pkg::Y_LIMIT) ? poff_pkg::Y_LIMIT : vertex_y;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MDX: begin mul_a = 27'(dx_q); mul_b = 19'(dx_q); end
			S_MDY: begin mul_a = 27'(dy_q); mul_b = 19'(dy_q); end
			S_MUX: begin mul_a = $signed({19'h0, dist_q}); mul_b = ux_q; end
			S_MUY: begin mul_a = $signed({19'h0, dist_q}); mul_b = uy_q; end
			S_DET1: begin mul_a = 27'(dsx); mul_b = 19'(day); end
			S_DET2: begin mul_a = 27'(dsy); mul_b = 19'(dax); end
			S_N1A: begin mul_a = 27'(sx_q); mul_b = 19'(ey_q); end
			S_N1B: begin mul_a = 27'(sy_q); mul_b = 19'(ex_q); end
			S_N2A: begin mul_a = 27'(ax_q); mul_b = 19'(by_q); end
			S_N2B: begin mul_a = 27'(ay_q); mul_b = 19'(bx_q); end
			S_NXB: begin mul_a = n1_q; mul_b = 19'(dax); end
			S_NXC: begin mul_a = n2_q; mul_b = 19'(dsx); end
			S_NYA: begin mul_a = n1_q; mul_b = 19'(day); end
			S_NYB: begin mul_a = n2_q; mul_b = 19'(dsy); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		sq_start = (state_q == S_LEN) && (len2 != 22'h0);
		dv_start = 1'b0;
		dv_dvd = {abs_diff};
		dv_dvs = abs_det;
		case (state_q)
			S_SQRT: begin
				dv_start = sq_stat.done;
				dv_dvd = {3'b000, abs_dy, 32'h0};
				dv_dvs = sq_root;
			end
			S_DIVX: begin
				dv_start = dv_stat.done;
				dv_dvd = {3'b000, abs_dx, 32'h0};
				dv_dvs = len_q;
			end
			S_NXD, S_NYD: begin
				dv_start = (det_q != 27'h0);
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	poff_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	poff_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(sq_rad),
		.root(sq_root), .stat(sq_stat)
	);

	poff_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_dvd),
		.divisor(dv_dvs), .quotient(dv_q), .stat(dv_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= poff_pkg::DIST_RESET;
		end else if (cfg_valid) begin
			dist_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 2'd0;
			lx_q <= '0;
			ly_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						vx_q <= vx_in;
						vy_q <= vy_in;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					par_q <= 1'b0;
					if (cnt_q == 2'd0) begin
						lx_q <= vx_q;
						ly_q <= vy_q;
						cnt_q <= 2'd1;
						state_q <= S_IDLE;
					end else begin
						dx_q <= $signed({1'b0, vx_q}) - $signed({1'b0, lx_q});
						dy_q <= $signed({1'b0, vy_q}) - $signed({1'b0, ly_q});
						state_q <= S_MDX;
					end
				end
				S_MDX: state_q <= S_MDY;
				S_MDY: begin
					acc_q <= prod;
					state_q <= S_LEN;
				end
				S_LEN: begin
					if (len2 != 22'h0) begin
						state_q <= S_SQRT;
					end else if (cnt_q == 2'd1) begin
						state_q <= S_IDLE;
					end else begin
						px_q <= bx_q;
						py_q <= by_q;
						rep_q <= 1'b1;
						parf_q <= 1'b1;
						last_q <= 1'b1;
						pend_q <= 1'b0;
						out_valid_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_SQRT: begin
					if (sq_stat.done) begin
						len_q <= sq_root;
						state_q <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (dv_stat.done) begin
						ux_q <= dy_q[10] ? -q19 : q19;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (dv_stat.done) begin
						uy_q <= dx_q[10] ? q19 : -q19;
						state_q <= S_MUX;
					end
				end
				S_MUX: state_q <= S_MUY;
				S_MUY: begin
					sx_q <= poff_pkg::trunc16(lx_q, prod[27:0]);
					ex_q <= poff_pkg::trunc16(vx_q, prod[27:0]);
					state_q <= S_OFSY;
				end
				S_OFSY: begin
					sy_q <= poff_pkg::trunc16(ly_q, prod[27:0]);
					ey_q <= poff_pkg::trunc16(vy_q, prod[27:0]);
					if (cnt_q == 2'd1) begin
						kx_q <= sx_q;
						ky_q <= poff_pkg::trunc16(ly_q, prod[27:0]);
						state_q <= S_FIN;
					end else begin
						state_q <= S_DET1;
					end
				end
				S_DET1: state_q <= S_DET2;
				S_DET2: begin
					acc_q <= prod;
					state_q <= S_DET3;
				end
				S_DET3: begin
					det_q <= diff[26:0];
					state_q <= S_N1A;
				end
				S_N1A: state_q <= S_N1B;
				S_N1B: begin
					acc_q <= prod;
					state_q <= S_N2A;
				end
				S_N2A: begin
					n1_q <= diff[26:0];
					state_q <= S_N2B;
				end
				S_N2B: begin
					acc_q <= prod;
					state_q <= S_NXA;
				end
				S_NXA: begin
					n2_q <= diff[26:0];
					state_q <= S_NXB;
				end
				S_NXB: state_q <= S_NXC;
				S_NXC: begin
					acc_q <= prod;
					state_q <= S_NXD;
				end
				S_NXD: begin
					neg_q <= diff[poff_pkg::MPW-1] ^ det_q[26];
					if (det_q == 27'h0) begin
						kx_q <= bx_q;
						ky_q <= by_q;
						par_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DVX;
					end
				end
				S_DVX: begin
					if (dv_stat.done) begin
						kx_q <= poff_pkg::sat_mag(dv_q, neg_q);
						state_q <= S_NYA;
					end
				end
				S_NYA: state_q <= S_NYB;
				S_NYB: begin
					acc_q <= prod;
					state_q <= S_NYD;
				end
				S_NYD: begin
					neg_q <= diff[poff_pkg::MPW-1] ^ det_q[26];
					state_q <= S_DVY;
				end
				S_DVY: begin
					if (dv_stat.done) begin
						ky_q <= poff_pkg::sat_mag(dv_q, neg_q);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					px_q <= kx_q;
					py_q <= ky_q;
					rep_q <= (cnt_q == 2'd2);
					parf_q <= par_q;
					last_q <= 1'b0;
					pend_x_q <= ex_q;
					pend_y_q <= ey_q;
					pend_q <= 1'b1;
					out_valid_q <= 1'b1;
					ax_q <= kx_q;
					ay_q <= ky_q;
					bx_q <= ex_q;
					by_q <= ey_q;
					lx_q <= vx_q;
					ly_q <= vy_q;
					cnt_q <= 2'd2;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (pend_q) begin
							px_q <= pend_x_q;
							py_q <= pend_y_q;
							rep_q <= 1'b0;
							parf_q <= 1'b0;
							last_q <= 1'b1;
							pend_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign replace_last = rep_q;
	assign parallel_flag = parf_q;
	assign last_of_run = last_q;

endmodule

>>> rtl/core/poff_checker.sv
module poff_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [9:0]          vertex_x,
	input logic [9:0]          vertex_y,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [12:0]  point_x,
	input logic signed [12:0]  point_y,
	input logic                replace_last,
	input logic                parallel_flag,
	input logic                last_of_run,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [7:0]          cfg_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y))
		else $error("stalled point changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("item taken while a result is pending");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
		else $error("second point of a segment missing");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !replace_last |-> !parallel_flag)
		else $error("appended point flagged parallel");

endmodule

bind polyline_offset_miter_core poff_checker u_poff_checker (.*);

>>> verif/polyline_offset_miter_core_test.sv
`timescale 1ns / 1ps

module polyline_offset_miter_core_test;

	typedef struct {
		logic signed [12:0] px;
		logic signed [12:0] py;
		logic rep;
		logic par;
		logic last;
	} offset_point_t;

	typedef struct {
		logic [9:0] x;
		logic [9:0] y;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] vertex_x = '0;
	logic [9:0] vertex_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [12:0] point_x;
	logic signed [12:0] point_y;
	logic replace_last;
	logic parallel_flag;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	polyline_offset_miter_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y),
		.replace_last(replace_last), .parallel_flag(parallel_flag),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vertex_t pending_vertices[$];
	offset_point_t expected_points[$];
	int fail_count = 0;

	// shadow state of the offset engine
	longint unsigned distance = 40;
	int seen_count = 0;
	longint last_vx = 0, last_vy = 0;
	longint start_x = 0, start_y = 0, end_x = 0, end_y = 0;

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_pt(longint v);
		if (v < -4096) return -4096;
		if (v > 4095) return 4095;
		return v;
	endfunction

	function automatic void push_point(longint x, longint y, logic rep, logic par,
			logic last);
		offset_point_t p;
		p.px = 13'(clamp_pt(x));
		p.py = 13'(clamp_pt(y));
		p.rep = rep;
		p.par = par;
		p.last = last;
		expected_points = {expected_points, p};
	endfunction

	function automatic void predict_offset(logic [9:0] rx, logic [9:0] ry);
		longint vx, vy, dx, dy, len2, ln, ux, uy, sx, sy, ex, ey;
		longint ax, ay, bx, by, det, n1, n2, kx, ky;
		logic par;
		vx = rx;
		vy = ry;
		if (vx > poff_pkg::CANVAS_WIDTH - 1) vx = poff_pkg::CANVAS_WIDTH - 1;
		if (vy > poff_pkg::CANVAS_HEIGHT - 1) vy = poff_pkg::CANVAS_HEIGHT - 1;
		if (seen_count == 0) begin
			last_vx = vx;
			last_vy = vy;
			seen_count = 1;
			return;
		end
		dx = vx - last_vx;
		dy = vy - last_vy;
		len2 = dx * dx + dy * dy;
		if (len2 == 0) begin
			if (seen_count == 2) push_point(end_x, end_y, 1'b1, 1'b1, 1'b1);
			return;
		end
		ln = longint'(root64(longint'(len2) << 32));
		ux = (dy * (64'sd1 <<< 32)) / ln;
		uy = (-dx * (64'sd1 <<< 32)) / ln;
		sx = (last_vx * 65536 + longint'(distance) * ux) / 65536;
		sy = (last_vy * 65536 + longint'(distance) * uy) / 65536;
		ex = (vx * 65536 + longint'(distance) * ux) / 65536;
		ey = (vy * 65536 + longint'(distance) * uy) / 65536;
		if (seen_count < 2) begin
			push_point(sx, sy, 1'b0, 1'b0, 1'b0);
			push_point(ex, ey, 1'b0, 1'b0, 1'b1);
			start_x = clamp_pt(sx);
			start_y = clamp_pt(sy);
		end else begin
			ax = start_x; ay = start_y; bx = end_x; by = end_y;
			det = (sx - ex) * (ay - by) - (sy - ey) * (ax - bx);
			par = 1'b0;
			if (det == 0) begin
				kx = bx;
				ky = by;
				par = 1'b1;
			end else begin
				n1 = sx * ey - sy * ex;
				n2 = ax * by - ay * bx;
				kx = clamp_pt((n1 * (ax - bx) - n2 * (sx - ex)) / det);
				ky = clamp_pt((n1 * (ay - by) - n2 * (sy - ey)) / det);
			end
			push_point(kx, ky, 1'b1, par, 1'b0);
			push_point(ex, ey, 1'b0, 1'b0, 1'b1);
			start_x = kx;
			start_y = ky;
		end
		end_x = clamp_pt(ex);
		end_y = clamp_pt(ey);
		last_vx = vx;
		last_vy = vy;
		seen_count = 2;
	endfunction

	// sender: bursts with random gaps
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		logic next_valid;
		vertex_t v;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_offset(vertex_x, vertex_y);
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
				next_valid = 1'b0;
			end else if (!in_valid && gap_left > 0) begin
				gap_left--;
			end
			if (!next_valid && gap_left == 0 && pending_vertices.size() > 0) begin
				v = pending_vertices.pop_front();
				vertex_x <= v.x;
				vertex_y <= v.y;
				next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
	end

	// receiver: stall pattern switching between modes
	int stall_mode = 0;
	int stall_span = 0;
	always @(posedge clk) begin
		offset_point_t e;
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 600);
		end
		stall_span--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 0);
			2: out_stall <= ($urandom_range(0, 7) != 0);
			default: out_stall <= ($urandom_range(0, 9) == 0);
		endcase
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$error("unexpected point x=%0d y=%0d", point_x, point_y);
				fail_count++;
			end else begin
				e = expected_points.pop_front();
				if (point_x !== e.px) begin
					$error("point_x expected %0d got %0d", e.px, point_x);
					fail_count++;
				end
				if (point_y !== e.py) begin
					$error("point_y expected %0d got %0d", e.py, point_y);
					fail_count++;
				end
				if (replace_last !== e.rep) begin
					$error("replace_last expected %0b got %0b", e.rep, replace_last);
					fail_count++;
				end
				if (parallel_flag !== e.par) begin
					$error("parallel_flag expected %0b got %0b", e.par, parallel_flag);
					fail_count++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0b got %0b", e.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	function automatic void add_vertex(int x, int y);
		vertex_t v;
		v.x = 10'(x);
		v.y = 10'(y);
		pending_vertices = {pending_vertices, v};
	endfunction

	int gen_px = 0, gen_py = 0, gen_lx = 0, gen_ly = 0;

	function automatic void add_random_vertices(int n);
		int x, y, k, r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				x = gen_lx;
				y = gen_ly;
			end else if (r < 18) begin
				k = $urandom_range(1, 3);
				if ($urandom_range(0, 2) == 0) k = -k;
				x = gen_lx + k * (gen_lx - gen_px);
				y = gen_ly + k * (gen_ly - gen_py);
				if (x < 0 || x > 1023 || y < 0 || y > 767) begin
					x = $urandom_range(0, 1023);
					y = $urandom_range(0, 767);
				end
			end else if (r < 24) begin
				x = $urandom_range(0, 1023);
				y = $urandom_range(0, 1023);
			end else if (r < 40) begin
				x = gen_lx + $urandom_range(0, 16) - 8;
				y = gen_ly + $urandom_range(0, 16) - 8;
				if (x < 0) x = 0;
				if (y < 0) y = 0;
				if (x > 1023) x = 1023;
				if (y > 767) y = 767;
			end else begin
				x = $urandom_range(0, 1023);
				y = $urandom_range(0, 767);
			end
			add_vertex(x, y);
			gen_px = gen_lx;
			gen_py = gen_ly;
			gen_lx = (x > 1023) ? 1023 : x;
			gen_ly = (y > 767) ? 767 : y;
		end
	endfunction

	task automatic wait_idle();
		while (pending_vertices.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_distance(logic [7:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		distance = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] settings[4];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero-length first segment, extremes, parallel, reversal, sharp miter
		add_vertex(0, 0);
		add_vertex(0, 0);
		add_vertex(1023, 767);
		add_vertex(1023, 767);
		add_vertex(1023, 1023);
		add_vertex(0, 0);
		add_vertex(512, 384);
		add_vertex(1023, 767);
		add_vertex(0, 0);
		add_vertex(1023, 0);
		add_vertex(0, 1);
		add_vertex(1023, 2);
		add_vertex(100, 700);
		add_vertex(200, 700);
		add_vertex(300, 700);
		add_vertex(300, 600);
		add_vertex(700, 500);
		add_vertex(682, 341);
		add_vertex(341, 682);
		add_vertex(0, 767);
		gen_px = 341; gen_py = 682; gen_lx = 0; gen_ly = 767;
		add_random_vertices(200);
		wait_idle();

		settings[0] = 8'd0;
		settings[1] = 8'd255;
		settings[2] = 8'($urandom_range(1, 254));
		settings[3] = 8'd1;
		foreach (settings[i]) begin
			write_distance(settings[i]);
			add_random_vertices(300);
			wait_idle();
		end

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
